>>> sv/rrtsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrtsq_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_SERVE = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // Result status codes.
  localparam logic [2:0] STATUS_ADDED    = 3'd0;
  localparam logic [2:0] STATUS_SLICED   = 3'd1;
  localparam logic [2:0] STATUS_FINISHED = 3'd2;
  localparam logic [2:0] STATUS_EMPTY    = 3'd3;
  localparam logic [2:0] STATUS_IGNORED  = 3'd4;
  localparam logic [2:0] STATUS_AVERAGE  = 3'd5;

  // Width of a job time and of the fixed-point fraction of the average.
  localparam int unsigned TIME_W = 16;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned AVG_W  = 24;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SERVE,
    ST_DIV
  } state_e;

endpackage

`default_nettype wire

>>> sv/round_robin_time_slice_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Round-robin time-slice queue.
// A request is taken when start_i is high and busy_o is low. kind_i selects
// add (burst_time_i goes to the tail), serve (the oldest job gets one slice
// and is requeued, or leaves) or query (mean remaining time in Q8).
// Each request gives one result: done_o is high for exactly one cycle with
// status_o, time_used_o, average_q8_o and jobs_waiting_o valid. The receiver
// cannot stall, so results are never held.
// Timing: add, ignored requests and serve or query on an empty ring finish
// in the idle state; the result appears the cycle after the request and the
// next request can be taken in that same cycle. A serve registers the head
// entry from the ring memory, then in the serve state writes a sliced job
// back and forms the result. A query on a non-empty ring runs a restoring
// divider, one quotient bit per cycle, and then gives the result.
// The quantum is written over the cfg channel, which is always ready; the user
// must write it only while the block is idle; the block does not enforce
// this. A quantum of zero acts as one. Reset empties the ring (no clearing
// pass: entries are read only after being written) and sets the quantum to one.
module round_robin_time_slice_queue
  import rrtsq_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [1:0]                          kind_i,
  input  wire logic [TIME_W-1:0]                   burst_time_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [TIME_W-1:0]                   cfg_data_i,
  output logic                                     done_o,
  output logic [2:0]                               status_o,
  output logic [TIME_W-1:0]                        time_used_o,
  output logic [AVG_W-1:0]                         average_q8_o,
  output logic [$clog2(RING_DEPTH+1)-1:0]          jobs_waiting_o
);

  localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W  = TIME_W + CNT_W;
  localparam int unsigned DIV_W  = SUM_W + FRAC_W;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  // Ring memory and its read data register.
  logic [TIME_W-1:0] ring_mem [RING_DEPTH];
  logic [TIME_W-1:0] rd_data_q;
  logic              rd_en;
  logic              wr_en;
  logic [TIME_W-1:0] wr_data;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [TIME_W-1:0] quantum_q;
  logic [TIME_W-1:0] quantum_eff;

  logic              done_q, done_d;
  logic [2:0]        status_q, status_d;
  logic [TIME_W-1:0] used_q, used_d;
  logic [AVG_W-1:0]  avg_q, avg_d;

  // Divider registers.
  logic [DIV_W-1:0]  div_acc_q, div_acc_d;
  logic [CNT_W:0]    div_rem_q, div_rem_d;
  logic [STEP_W-1:0] div_step_q, div_step_d;
  logic [CNT_W:0]    rem_shift;
  logic              rem_ge;
  logic [DIV_W-1:0]  acc_next;

  logic              accept;
  logic              sliced;
  logic              add_ok;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign quantum_eff = (quantum_q == '0) ? TIME_W'(1) : quantum_q;

  assign add_ok = (kind_i == KIND_ADD) && (burst_time_i != '0) &&
                  (count_q < CNT_W'(RING_DEPTH));
  assign sliced = ({1'b0, rd_data_q} > {1'b0, quantum_eff});
  assign rd_en  = accept && (kind_i == KIND_SERVE) && (count_q != '0);

  // One divider step: shift in the next dividend bit and try to subtract.
  assign rem_shift = {div_rem_q[CNT_W-1:0], div_acc_q[DIV_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, count_q});
  assign acc_next  = {div_acc_q[DIV_W-2:0], rem_ge};

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    ring_next = (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (kind_i == KIND_SERVE) && (count_q != '0)) begin
          state_d = ST_SERVE;
        end else if (accept && (kind_i == KIND_QUERY) && (count_q != '0)) begin
          state_d = ST_DIV;
        end
      end
      ST_SERVE: state_d = ST_IDLE;
      ST_DIV: begin
        if (div_step_q == STEP_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and result formation.
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    sum_d      = sum_q;
    done_d     = 1'b0;
    status_d   = status_q;
    used_d     = used_q;
    avg_d      = avg_q;
    div_acc_d  = div_acc_q;
    div_rem_d  = div_rem_q;
    div_step_d = div_step_q;
    wr_en      = 1'b0;
    wr_data    = burst_time_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          used_d = '0;
          avg_d  = '0;
          case (kind_i)
            KIND_ADD: begin
              done_d   = 1'b1;
              status_d = STATUS_IGNORED;
              if (add_ok) begin
                wr_en    = 1'b1;
                tail_d   = ring_next(tail_q);
                count_d  = count_q + CNT_W'(1);
                sum_d    = sum_q + SUM_W'(burst_time_i);
                status_d = STATUS_ADDED;
              end
            end
            KIND_SERVE: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = STATUS_EMPTY;
              end
            end
            KIND_QUERY: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = STATUS_AVERAGE;
              end else begin
                div_acc_d  = {sum_q, FRAC_W'(0)};
                div_rem_d  = '0;
                div_step_d = STEP_W'(DIV_W);
              end
            end
            default: begin
              done_d   = 1'b1;
              status_d = STATUS_IGNORED;
            end
          endcase
        end
      end
      ST_SERVE: begin
        // The head entry leaves; a sliced job is written back at the tail.
        done_d = 1'b1;
        head_d = ring_next(head_q);
        if (sliced) begin
          wr_en    = 1'b1;
          wr_data  = rd_data_q - quantum_eff;
          tail_d   = ring_next(tail_q);
          sum_d    = sum_q - SUM_W'(quantum_eff);
          status_d = STATUS_SLICED;
          used_d   = quantum_eff;
        end else begin
          count_d  = count_q - CNT_W'(1);
          sum_d    = sum_q - SUM_W'(rd_data_q);
          status_d = STATUS_FINISHED;
          used_d   = rd_data_q;
        end
      end
      ST_DIV: begin
        div_acc_d  = acc_next;
        div_rem_d  = rem_ge ? (rem_shift - {1'b0, count_q}) : rem_shift;
        div_step_d = div_step_q - STEP_W'(1);
        if (div_step_q == STEP_W'(1)) begin
          done_d   = 1'b1;
          status_d = STATUS_AVERAGE;
          avg_d    = AVG_W'(acc_next);
        end
      end
      default: begin
      end
    endcase
  end

  // Ring memory write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[tail_q] <= wr_data;
    end
  end

  // Ring memory read port, registered.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= ring_mem[head_q];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      sum_q     <= '0;
      quantum_q <= TIME_W'(1);
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        quantum_q <= cfg_data_i;
      end
    end
  end

  // Result and divider payload.
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    used_q     <= used_d;
    avg_q      <= avg_d;
    div_acc_q  <= div_acc_d;
    div_rem_q  <= div_rem_d;
    div_step_q <= div_step_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign time_used_o    = used_q;
  assign average_q8_o   = avg_q;
  assign jobs_waiting_o = count_q;

`ifndef SYNTH
  // The job count never exceeds the ring depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(RING_DEPTH))
    else $error("job count exceeds ring depth");

  // A result follows either an accepted request or a finishing multi-cycle step.
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start_i && !busy_o) || $past(state_q != ST_IDLE)))
    else $error("result without a request");

  // The divider only runs on a non-empty ring.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (count_q != '0))
    else $error("divide by zero job count");

  // A serve step always ends with a result in the next cycle.
  a_serve_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SERVE) |=> (done_o && (state_q == ST_IDLE)))
    else $error("serve step did not complete");
`endif

endmodule

`default_nettype wire
